>>> rtl/tse_pkg.sv
// Package for the tab-to-space expander: character codes, mode codes and
// the structs passed between the step logic and the top level.
// No dependencies.
package tse_pkg;

    // Character codes.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Pending blank count saturates at the largest 16-bit value.
    localparam logic [15:0] PENDING_MAX = 16'hFFFF;

    // Filter mode codes.
    localparam logic [1:0] MODE_BYPASS   = 2'd0;
    localparam logic [1:0] MODE_LEADING  = 2'd1;
    localparam logic [1:0] MODE_COMBINED = 2'd2;
    localparam logic [1:0] MODE_ALL      = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] REG_FILTER_MODE = 8'd0;
    localparam logic [7:0] REG_TAB_WIDTH   = 8'd1;

    typedef struct packed {
        logic [1:0] filter_mode;
        logic [7:0] tab_width;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  tab_phase;
        logic [15:0] pending_spaces;
        logic        nonspace_seen;
    } t_line_state;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] space_count;
    } t_result;

endpackage

>>> rtl/tse_step.sv
// Step logic of the tab-to-space expander: from the line state, the
// configuration and one byte it forms the next line state and the result.
// Depends on tse_pkg.
module tse_step
    import tse_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_line_state i_state,
    input  logic [7:0]  i_byte,
    output t_line_state o_state,
    output logic        o_emit,
    output t_result     o_result
);

    logic        bypass;
    logic        tracks_line;
    logic        is_tab;
    logic        leading_tab;
    logic        stop_tab;
    logic [7:0]  add_amt;
    logic [16:0] add_sum;
    logic [15:0] pending_sat;
    logic [8:0]  phase_inc;
    logic [7:0]  phase_next;

    // Decode the mode and the kind of byte.
    assign bypass      = (i_cfg.filter_mode == MODE_BYPASS) || (i_cfg.tab_width == 8'd0);
    assign tracks_line = (i_cfg.filter_mode == MODE_LEADING)
                      || (i_cfg.filter_mode == MODE_COMBINED);
    assign is_tab      = (i_byte == CH_TAB);
    assign leading_tab = is_tab && tracks_line && !i_state.nonspace_seen;
    assign stop_tab    = is_tab && !leading_tab && (i_cfg.filter_mode != MODE_LEADING);

    // Blanks to add: a full stop, the rest of the stop, or one space.
    always_comb begin
        if (leading_tab) begin
            add_amt = i_cfg.tab_width;
        end else if (stop_tab) begin
            add_amt = i_cfg.tab_width - i_state.tab_phase;
        end else begin
            add_amt = 8'd1;
        end
    end

    assign add_sum     = {1'b0, i_state.pending_spaces} + {9'd0, add_amt};
    assign pending_sat = add_sum[16] ? PENDING_MAX : add_sum[15:0];

    // Column advance, wrapping at the tab width.
    assign phase_inc  = {1'b0, i_state.tab_phase} + 9'd1;
    assign phase_next = (phase_inc >= {1'b0, i_cfg.tab_width}) ? 8'd0 : phase_inc[7:0];

    always_comb begin
        o_state              = i_state;
        o_emit               = 1'b1;
        o_result.out_byte    = i_byte;
        o_result.space_count = i_state.pending_spaces;
        if (bypass) begin
            o_result.space_count = 16'd0;
        end else if (leading_tab) begin
            o_state.pending_spaces = pending_sat;
            o_emit                 = 1'b0;
        end else if (stop_tab) begin
            o_state.pending_spaces = pending_sat;
            o_state.tab_phase      = 8'd0;
            o_emit                 = 1'b0;
        end else if (i_byte == CH_SPACE) begin
            o_state.pending_spaces = pending_sat;
            o_state.tab_phase      = phase_next;
            o_emit                 = 1'b0;
        end else if (i_byte == CH_NEWLINE) begin
            // Only the leading-tabs mode keeps trailing blanks.
            if (i_cfg.filter_mode != MODE_LEADING) begin
                o_result.space_count = 16'd0;
            end
            o_state.tab_phase      = 8'd0;
            o_state.pending_spaces = 16'd0;
            if (tracks_line) begin
                o_state.nonspace_seen = 1'b0;
            end
        end else begin
            // Ordinary byte, or a later tab in the leading-tabs mode.
            o_state.pending_spaces = 16'd0;
            o_state.tab_phase      = phase_next;
            if (tracks_line) begin
                o_state.nonspace_seen = 1'b1;
            end
        end
    end

endmodule

>>> rtl/tab_to_space_expander.sv
// Top level of the tab-to-space expander: configuration registers, input
// register, line state and result register. Depends on tse_pkg, tse_step.
//
// The block takes one text byte per transfer and turns tabs into counts of
// spaces. In bypass every byte passes with a zero count; otherwise blanks and
// expanded tabs are held back and make no result, and each ordinary byte or
// newline comes out as one result carrying the number of spaces to place
// before it. Throughput is one byte per clock unless the result stream stalls
// a byte that makes a result. A byte passes the input register; the step
// logic then updates the line state and fills the result register in the
// same cycle. The only recurrence is the line state update, short adds and
// compares. Write filter_mode (index 0) and tab_width (index 1) only while
// the block is idle; a tab_width write restarts the column count.
module tab_to_space_expander
    import tse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] space_count, [23:16] out_byte
);

    t_cfg        r_cfg;
    t_line_state r_state;
    t_line_state n_state;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out_data;
    t_result     step_result;
    logic        step_emit;
    logic        advance;
    logic        cfg_write;

    tse_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // The held byte moves on when it makes no result or the result slot frees.
    assign advance       = r_in_valid && (!step_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign cfg_write     = i_cfg_valid && o_cfg_ready;

    // Configuration registers and line state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_state <= '0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (cfg_write && (i_cfg_index == REG_FILTER_MODE)) begin
                r_cfg.filter_mode <= i_cfg_data[1:0];
            end
            if (cfg_write && (i_cfg_index == REG_TAB_WIDTH)) begin
                r_cfg.tab_width   <= i_cfg_data;
                r_state.tab_phase <= 8'd0;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out_data <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> bench/tab_to_space_expander_tb.sv
// Self-checking testbench for tab_to_space_expander: a queue-fed stream driver,
// a result monitor and a line-state predictor of its own.
// Depends on tse_pkg and the tab_to_space_expander RTL.
`timescale 1ns / 100ps

module tab_to_space_expander_tb
    import tse_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 105;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [15:0] space_count, [23:16] out_byte

    // Bytes waiting to be offered, and the expanded results still owed.
    logic [7:0] byte_stream[$];
    t_result    expected_emits[$];

    // Predictor copy of the configuration and the line state.
    logic [1:0]  cfg_mode = MODE_BYPASS;
    logic [7:0]  cfg_width = '0;
    logic [7:0]  line_phase = '0;
    logic [15:0] blank_count = '0;
    logic        text_seen = 1'b0;

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int queued = 0;
    logic hold_armed = 1'b0;
    int hold_count = 0;

    tab_to_space_expander dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Generous overall limit on the run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag_error(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // Add held-back blanks, saturating at the top of the 16-bit count.
    function automatic void add_blanks(input logic [15:0] n);
        logic [16:0] sum;
        sum = {1'b0, blank_count} + {1'b0, n};
        blank_count = sum[16] ? PENDING_MAX : sum[15:0];
    endfunction

    function automatic void step_column();
        line_phase = ({1'b0, line_phase} + 9'd1 >= {1'b0, cfg_width}) ? 8'd0 : line_phase + 8'd1;
    endfunction

    // Work out what one accepted byte produces and update the line state.
    function automatic void expand_byte(input logic [7:0] b);
        t_result r;
        logic    tracks;
        tracks = (cfg_mode == MODE_LEADING) || (cfg_mode == MODE_COMBINED);
        if (cfg_mode == MODE_BYPASS || cfg_width == 8'd0) begin
            r.space_count = '0;
            r.out_byte = b;
            expected_emits = {expected_emits, r};
        end else if (b == CH_TAB && tracks && !text_seen) begin
            // Leading tab: a full width, column unchanged.
            add_blanks({8'd0, cfg_width});
        end else if (b == CH_TAB && cfg_mode != MODE_LEADING) begin
            // Tab to the next stop.
            add_blanks({8'd0, cfg_width - line_phase});
            line_phase = '0;
        end else if (b == CH_SPACE) begin
            add_blanks(16'd1);
            step_column();
        end else if (b == CH_NEWLINE) begin
            // Only the leading-tabs mode keeps trailing blanks.
            r.space_count = (cfg_mode == MODE_LEADING) ? blank_count : 16'd0;
            r.out_byte = CH_NEWLINE;
            expected_emits = {expected_emits, r};
            line_phase = '0;
            blank_count = '0;
            if (tracks) text_seen = 1'b0;
        end else begin
            // Ordinary byte, or a later tab in the leading-tabs mode.
            r.space_count = blank_count;
            r.out_byte = b;
            expected_emits = {expected_emits, r};
            blank_count = '0;
            step_column();
            if (tracks) text_seen = 1'b1;
        end
    endfunction

    // Input driver: offers queued bytes and predicts each accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expand_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= byte_stream.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off when armed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_count <= 0;
        end else if (hold_armed && hold_count < HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor: each transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_emits.size() == 0) begin
                flag_error($sformatf("unexpected result tdata=%h", m_axis_tdata));
            end else begin
                want = expected_emits.pop_front();
                if (m_axis_tdata[15:0] !== want.space_count)
                    flag_error($sformatf("space_count %0d, expected %0d",
                                         m_axis_tdata[15:0], want.space_count));
                if (m_axis_tdata[23:16] !== want.out_byte)
                    flag_error($sformatf("out_byte %h, expected %h",
                                         m_axis_tdata[23:16], want.out_byte));
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        byte_stream = {byte_stream, b};
        queued++;
    endtask

    // One configuration transfer; the predictor follows it once accepted.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FILTER_MODE) begin
            cfg_mode = val[1:0];
        end else if (idx == REG_TAB_WIDTH) begin
            cfg_width = val;
            line_phase = '0;
        end
    endtask

    // Wait until everything sent has been answered and the pipeline is empty.
    // The check runs at the falling edge, once the driver's updates have settled.
    task automatic drain();
        while (byte_stream.size() != 0 || s_axis_tvalid || expected_emits.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_blank();
        put_byte($urandom_range(1) ? CH_TAB : CH_SPACE);
    endtask

    // A text line (leading blanks, words with blanks between, mostly a newline) or noise.
    task automatic queue_line();
        int lead;
        int words;
        int len;
        int gap;
        if ($urandom_range(9) == 0) begin
            // Noise: arbitrary bytes, control codes included.
            len = $urandom_range(1, 8);
            repeat (len) put_byte(8'($urandom_range(255)));
        end else begin
            lead = $urandom_range(4);
            repeat (lead) put_blank();
            words = $urandom_range(4);
            repeat (words) begin
                len = $urandom_range(1, 6);
                repeat (len) put_byte(8'($urandom_range(8'h21, 8'h7E)));
                gap = $urandom_range(3);
                repeat (gap) put_blank();
            end
            if ($urandom_range(99) < 85) put_byte(CH_NEWLINE);
        end
    endtask

    task automatic set_idling(input int sched);
        case (sched)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 54;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 54;
            end
            default: begin
                send_idle_pct = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    // Main sequence: directed lines under fixed settings, then random phases.
    initial begin
        logic [1:0] m;
        int pick;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings pass every byte through, extremes included.
        set_idling(0);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_TAB);
        put_byte(CH_SPACE);
        put_byte(CH_NEWLINE);
        put_byte(8'h61);
        drain();

        // Leading tabs only: a later tab passes as an ordinary byte.
        write_reg(REG_FILTER_MODE, {6'd0, MODE_LEADING});
        write_reg(REG_TAB_WIDTH, 8'd4);
        put_byte(CH_TAB);
        put_byte(CH_SPACE);
        put_byte(CH_TAB);
        put_byte(8'h78);
        put_byte(CH_SPACE);
        put_byte(CH_TAB);
        put_byte(CH_SPACE);
        put_byte(CH_NEWLINE);
        drain();

        // Combined: full-width leading tab, later tab to the stop, blanks dropped.
        write_reg(REG_FILTER_MODE, {6'd0, MODE_COMBINED});
        write_reg(REG_TAB_WIDTH, 8'd8);
        put_byte(CH_TAB);
        put_byte(8'h61);
        put_byte(CH_TAB);
        put_byte(8'h62);
        put_byte(CH_SPACE);
        put_byte(CH_SPACE);
        put_byte(CH_NEWLINE);
        drain();

        // All tabs to stops; upper data bits of the mode write are ignored.
        write_reg(REG_FILTER_MODE, 8'hFF);
        write_reg(REG_TAB_WIDTH, 8'd3);
        put_byte(8'h61);
        put_byte(CH_TAB);
        put_byte(CH_SPACE);
        put_byte(CH_TAB);
        put_byte(8'h62);
        put_byte(CH_NEWLINE);
        drain();

        // A zero tab width forces bypass; unknown register indexes are ignored.
        write_reg(REG_TAB_WIDTH, 8'd0);
        write_reg(8'd2, 8'h55);
        write_reg(8'hFF, 8'hAA);
        put_byte(CH_TAB);
        put_byte(CH_SPACE);
        drain();

        // Saturation of the blank count: widest tabs, then a kept newline.
        write_reg(REG_FILTER_MODE, {6'd0, MODE_LEADING});
        write_reg(REG_TAB_WIDTH, 8'd255);
        repeat (258) put_byte(CH_TAB);
        put_byte(CH_NEWLINE);
        drain();
        write_reg(REG_FILTER_MODE, {6'd0, MODE_ALL});
        repeat (258) put_byte(CH_TAB);
        put_byte(8'h7A);
        drain();

        // Random phases: new settings each time, state carries across phases.
        for (int p = 0; p < 8; p++) begin
            m = 2'($urandom_range(3));
            write_reg(REG_FILTER_MODE, {6'($urandom_range(63)), m});
            pick = $urandom_range(9);
            if (p == 0 || $urandom_range(3) != 0) begin
                case (pick)
                    0: write_reg(REG_TAB_WIDTH, 8'd0);
                    1: write_reg(REG_TAB_WIDTH, 8'd255);
                    2: write_reg(REG_TAB_WIDTH, 8'd1);
                    3: write_reg(REG_TAB_WIDTH, 8'($urandom_range(255)));
                    default: write_reg(REG_TAB_WIDTH, 8'($urandom_range(2, 8)));
                endcase
            end
            set_idling(p % 4);
            // One phase holds the receiver off while the sender keeps offering.
            if (p == 5) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_armed = 1'b1;
            end
            queued = 0;
            while (queued < PHASE_ITEMS) queue_line();
            drain();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/tse_pkg.sv
rtl/tse_step.sv
rtl/tab_to_space_expander.sv
bench/tab_to_space_expander_tb.sv
